// ===== hdl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker package
// Command and verdict codes, register indexes, beat types and fixed limits
// shared by the tracker and its port checker.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam int MAX_CHUNKS_DEF = 1024;
   localparam int MAX_RANGES     = 64;

   // The received bitmap is stored as rows of WORD_BITS flags.
   localparam int WORD_BITS = 32;
   localparam int BIT_AW    = 5;

   localparam int CSR_AW = 3;

   localparam logic [15:0] MIN_FRAME     = 16'd6;
   localparam logic [15:0] BEGIN_LEN     = 16'd22;
   localparam logic [15:0] CHUNK_HDR_LEN = 16'd16;

   localparam logic [24:0] STAGE_CAP_RESET = 25'd1048576;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_BEGIN  = 2'd1,
      CMD_CHUNK  = 2'd2,
      CMD_REPORT = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      V_STAGED   = 4'd0,
      V_MANIFEST = 4'd1,
      V_SHORT    = 4'd2,
      V_MAGIC    = 4'd3,
      V_LENGTH   = 4'd4,
      V_SEQ      = 4'd5,
      V_CRC      = 4'd6,
      V_DUP      = 4'd7,
      V_BOUND    = 4'd8,
      V_TOO_BIG  = 4'd9,
      V_CLEARED  = 4'd10
   } verdict_type;

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_RANGE   = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_MAGIC    = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_idx_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] datagram_len;
      logic [31:0] frame_magic;
      logic [15:0] announced_total;
      logic [15:0] announced_chunk_size;
      logic [15:0] chunk_index;
      logic [15:0] body_len;
      logic [31:0] header_crc;
      logic [31:0] payload_crc;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      verdict_type verdict;
      logic [23:0] stage_offset;
      logic        range_valid;
      logic [9:0]  range_start;
      logic [9:0]  range_end;
      logic [6:0]  range_count;
      logic [10:0] have_count;
      logic        last;
   } rsp_type;

endpackage

// ===== hdl/chunk_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker
// Begin and chunk commands: the row is read on start; the decode state checks
// the frame, sets the chunk's flag by a read-modify-write of that row and
// registers the result. No new command is taken while busy. Clear command:
// zeroes each of the ceil(MAX_CHUNKS/32) bitmap rows, then gives a cleared
// verdict. Report: rows are read and scanned. Results cannot be stalled.
// Synchronous reset clears the session and zeroes every row with busy high.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker #(
   parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  crt_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output crt_pkg::rsp_type          rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [crt_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int ROWS   = (MAX_CHUNKS + crt_pkg::WORD_BITS - 1) / crt_pkg::WORD_BITS;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW     = $clog2(MAX_CHUNKS + 1);
   localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);
   localparam logic [16:0]       MAX_CHK_W = 17'(MAX_CHUNKS);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_CLR      = 6'b000010,
      S_DEC      = 6'b000100,
      S_REP_RD   = 6'b001000,
      S_REP_SCAN = 6'b010000,
      S_REP_FIN  = 6'b100000
   } state_type;

   function automatic logic [ROW_AW-1:0] row_of(input logic [15:0] idx);
      return idx[ROW_AW+crt_pkg::BIT_AW-1:crt_pkg::BIT_AW];
   endfunction

   // Control state
   state_type         state_ff, state_in;
   logic              manifest_ff, manifest_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [15:0]       csize_ff, csize_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [ROW_AW-1:0] sweep_ff, sweep_in;
   logic              clr_emit_ff, clr_emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       magic_ff, magic_in;
   logic [24:0]       cap_ff, cap_in;

   // Command and walk payload
   crt_pkg::req_type  req_ff, req_in;
   logic [31:0]       product_ff, product_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic              open_ff, open_in;
   logic [CW-1:0]     start_ff, start_in;
   logic [6:0]        nr_ff, nr_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CW-1:0]     pend_start_ff, pend_start_in;
   logic [CW-1:0]     pend_end_ff, pend_end_in;
   logic [6:0]        pend_count_ff, pend_count_in;
   crt_pkg::rsp_type  rsp_ff, rsp_in;

   // Bitmap memory
   logic [crt_pkg::WORD_BITS-1:0] bitmap_mem [ROWS];
   logic [crt_pkg::WORD_BITS-1:0] rd_row_ff;
   logic                          mem_we;
   logic [ROW_AW-1:0]             mem_waddr;
   logic [crt_pkg::WORD_BITS-1:0] mem_wdata;
   logic                          mem_re;
   logic [ROW_AW-1:0]             mem_raddr;

   logic                 cfg_write;
   crt_pkg::csr_idx_type csr_idx;
   logic [15:0]          cur16;
   logic [15:0]          nxt16;
   logic                 cur_bit;
   logic [16:0]          len_sum;
   logic [32:0]          chunk_end;
   crt_pkg::verdict_type verdict_v;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_idx    = crt_pkg::csr_idx_type'(csr_paddr[2]);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   assign cur16     = 16'(cursor_ff);
   assign nxt16     = cur16 + 16'd1;
   assign cur_bit   = rd_row_ff[cur16[crt_pkg::BIT_AW-1:0]];
   assign len_sum   = 17'(crt_pkg::CHUNK_HDR_LEN) + 17'(req_ff.body_len);
   assign chunk_end = {1'b0, product_ff} + 33'(req_ff.body_len);

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         crt_pkg::CSR_MAGIC:    csr_prdata = magic_ff;
         crt_pkg::CSR_CAPACITY: csr_prdata = 32'(cap_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_comb begin
      magic_in = magic_ff;
      cap_in   = cap_ff;
      if (cfg_write) begin
         case (csr_idx)
            crt_pkg::CSR_MAGIC:    magic_in = csr_pwdata;
            crt_pkg::CSR_CAPACITY: cap_in   = csr_pwdata[24:0];
            default:               magic_in = magic_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      manifest_in   = manifest_ff;
      total_in      = total_ff;
      csize_in      = csize_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      clr_emit_in   = clr_emit_ff;
      req_in        = req_ff;
      product_in    = product_ff;
      cursor_in     = cursor_ff;
      open_in       = open_ff;
      start_in      = start_ff;
      nr_in         = nr_ff;
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      pend_count_in = pend_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      verdict_v     = crt_pkg::V_STAGED;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               product_in = 32'(req_data.chunk_index) * 32'(csize_ff);
               mem_re     = 1'b1;
               mem_raddr  = row_of(req_data.chunk_index);
               case (req_data.command)
                  crt_pkg::CMD_CLEAR: begin
                     manifest_in = 1'b0;
                     total_in    = '0;
                     csize_in    = '0;
                     count_in    = '0;
                     sweep_in    = '0;
                     clr_emit_in = 1'b1;
                     state_in    = S_CLR;
                  end
                  crt_pkg::CMD_BEGIN,
                  crt_pkg::CMD_CHUNK: begin
                     state_in = S_DEC;
                  end
                  crt_pkg::CMD_REPORT: begin
                     cursor_in     = '0;
                     open_in       = 1'b0;
                     nr_in         = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_REP_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == LAST_ROW) begin
               state_in = S_IDLE;
               if (clr_emit_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.verdict = crt_pkg::V_CLEARED;
                  rsp_in.last    = 1'b1;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_DEC: begin
            if (req_ff.command == crt_pkg::CMD_BEGIN) begin
               if (req_ff.datagram_len < crt_pkg::MIN_FRAME) begin
                  verdict_v = crt_pkg::V_SHORT;
               end else if (req_ff.frame_magic != magic_ff) begin
                  verdict_v = crt_pkg::V_MAGIC;
               end else if (req_ff.datagram_len < crt_pkg::BEGIN_LEN) begin
                  verdict_v = crt_pkg::V_SHORT;
               end else if (17'(req_ff.announced_total) > MAX_CHK_W) begin
                  verdict_v = crt_pkg::V_TOO_BIG;
               end else begin
                  verdict_v   = crt_pkg::V_STAGED;
                  manifest_in = 1'b1;
                  total_in    = CW'(req_ff.announced_total);
                  csize_in    = req_ff.announced_chunk_size;
               end
            end else begin
               if (req_ff.datagram_len < crt_pkg::MIN_FRAME) begin
                  verdict_v = crt_pkg::V_SHORT;
               end else if (req_ff.frame_magic != magic_ff) begin
                  verdict_v = crt_pkg::V_MAGIC;
               end else if (req_ff.datagram_len < crt_pkg::CHUNK_HDR_LEN) begin
                  verdict_v = crt_pkg::V_SHORT;
               end else if (len_sum != 17'(req_ff.datagram_len)) begin
                  verdict_v = crt_pkg::V_LENGTH;
               end else if (!manifest_ff) begin
                  verdict_v = crt_pkg::V_MANIFEST;
               end else if (17'(req_ff.chunk_index) >= 17'(total_ff)) begin
                  verdict_v = crt_pkg::V_SEQ;
               end else if (req_ff.payload_crc != req_ff.header_crc) begin
                  verdict_v = crt_pkg::V_CRC;
               end else if (rd_row_ff[req_ff.chunk_index[crt_pkg::BIT_AW-1:0]]) begin
                  verdict_v = crt_pkg::V_DUP;
               end else if (chunk_end > 33'(cap_ff)) begin
                  verdict_v = crt_pkg::V_BOUND;
               end else begin
                  verdict_v           = crt_pkg::V_STAGED;
                  mem_we              = 1'b1;
                  mem_waddr           = row_of(req_ff.chunk_index);
                  mem_wdata           = rd_row_ff |
                                        (crt_pkg::WORD_BITS'(1) <<
                                         req_ff.chunk_index[crt_pkg::BIT_AW-1:0]);
                  count_in            = count_ff + 1'b1;
                  rsp_in.stage_offset = product_ff[23:0];
               end
            end
            rsp_valid_in   = 1'b1;
            rsp_in.verdict = verdict_v;
            rsp_in.last    = 1'b1;
            state_in       = S_IDLE;
         end

         S_REP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = row_of(cur16);
            state_in  = S_REP_SCAN;
         end

         S_REP_SCAN: begin
            // A closed range waits in the pending slot, so the final entry of
            // the report can still be marked last when the walk ends.
            if ((cursor_ff >= total_ff) || (cur_bit && open_ff)) begin
               if (open_ff) begin
                  nr_in         = nr_ff + 7'd1;
                  open_in       = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_start_in = start_ff;
                  pend_end_in   = cursor_ff - 1'b1;
                  pend_count_in = nr_ff + 7'd1;
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.result_kind = crt_pkg::KIND_RANGE;
                     rsp_in.range_valid = 1'b1;
                     rsp_in.range_start = 10'(pend_start_ff);
                     rsp_in.range_end   = 10'(pend_end_ff);
                     rsp_in.range_count = pend_count_ff;
                  end
               end
            end else if (!cur_bit && !open_ff) begin
               open_in  = 1'b1;
               start_in = cursor_ff;
            end

            if ((cursor_ff >= total_ff) ||
                (cur_bit && open_ff && ((nr_ff + 7'd1) == 7'(crt_pkg::MAX_RANGES)))) begin
               state_in = S_REP_FIN;
            end else begin
               cursor_in = CW'(nxt16);
               if (nxt16[crt_pkg::BIT_AW-1:0] == '0) begin
                  state_in = S_REP_RD;
               end
            end
         end

         S_REP_FIN: begin
            rsp_valid_in       = 1'b1;
            rsp_in.result_kind = crt_pkg::KIND_RANGE;
            rsp_in.last        = 1'b1;
            if (pend_valid_ff) begin
               rsp_in.range_valid = 1'b1;
               rsp_in.range_start = 10'(pend_start_ff);
               rsp_in.range_end   = 10'(pend_end_ff);
               rsp_in.range_count = pend_count_ff;
            end
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      rsp_in.have_count = 11'(count_in);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= bitmap_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         manifest_ff  <= 1'b0;
         total_ff     <= '0;
         csize_ff     <= '0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         clr_emit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         magic_ff     <= '0;
         cap_ff       <= crt_pkg::STAGE_CAP_RESET;
      end else begin
         state_ff     <= state_in;
         manifest_ff  <= manifest_in;
         total_ff     <= total_in;
         csize_ff     <= csize_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         clr_emit_ff  <= clr_emit_in;
         rsp_valid_ff <= rsp_valid_in;
         magic_ff     <= magic_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      product_ff    <= product_in;
      cursor_ff     <= cursor_in;
      open_ff       <= open_in;
      start_ff      <= start_in;
      nr_ff         <= nr_in;
      pend_valid_ff <= pend_valid_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      pend_count_ff <= pend_count_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// ===== hdl/crt_checker.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker port checker
// Watches the command and result ports for ordering and framing of results.
// ----------------------------------------------------------------------------
module crt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input crt_pkg::req_type req_data,
   input logic             rsp_valid,
   input crt_pkg::rsp_type rsp_data
);

   // Every result beat comes out of work that kept the block busy.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a command in progress");

   // Begin and chunk frames taken in idle get a verdict beat marked last.
   a_frame_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy &&
       (req_data.command == crt_pkg::CMD_BEGIN || req_data.command == crt_pkg::CMD_CHUNK))
      |-> ##2 (rsp_valid && rsp_data.last &&
               rsp_data.result_kind == crt_pkg::KIND_VERDICT))
      else $error("frame verdict missing or late");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == crt_pkg::KIND_VERDICT) |-> rsp_data.last)
      else $error("verdict beat not marked last");

   // An empty report entry only stands alone, with no ranges counted.
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == crt_pkg::KIND_RANGE && !rsp_data.range_valid)
      |-> (rsp_data.last && rsp_data.range_count == 7'd0))
      else $error("empty report entry malformed");

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
